[rtl/ttcw_pkg.sv]
package ttcw_pkg;

  // Screen geometry
  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 24;
  localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(CELL_COUNT);

  // Field widths
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int COL_W     = 7;
  localparam int ROW_W     = 5;
  localparam int OFFS_W    = 11;
  localparam int CELL_W    = CHAR_W + ATTR_W;
  localparam int COL_SUM_W = COL_W + 1;

  localparam int TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] CR_CHAR      = 8'h0D;
  localparam logic [CHAR_W-1:0] TAB_CHAR     = 8'h09;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_SET   = 2'd2,
    REQ_READ  = 2'd3
  } req_type_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } mem_rd_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [CHAR_W-1:0] ch,
                                                  input logic [ATTR_W-1:0] attr);
    return {attr, ch};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(col);
  endfunction

endpackage

[rtl/ttcw_ifs.sv]
interface ttcw_req_if;
  import ttcw_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] char_code;
  logic [COL_W-1:0]  col_value;
  logic [ROW_W-1:0]  row_value;
  modport source(output valid, req_type, char_code, col_value, row_value, input ready);
  modport sink(input valid, req_type, char_code, col_value, row_value, output ready);
endinterface

interface ttcw_rsp_if;
  import ttcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [OFFS_W-1:0] cursor_offset;
  logic [CELL_W-1:0] cell_data;
  modport source(output valid, cursor_offset, cell_data, input ready);
  modport sink(input valid, cursor_offset, cell_data, output ready);
endinterface

interface ttcw_cfg_if;
  import ttcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ATTR_W-1:0] color_attr;
  modport source(output valid, color_attr, input ready);
  modport sink(input valid, color_attr, output ready);
endinterface

[rtl/ttcw_screen_mem.sv]
module ttcw_screen_mem (
  input  logic                    clk,
  input  ttcw_pkg::mem_wr_t       wr,
  input  ttcw_pkg::mem_rd_t       rd,
  output logic [ttcw_pkg::CELL_W-1:0] rd_data
);
  import ttcw_pkg::*;

  logic [CELL_W-1:0] mem [CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[rtl/ttcw_ctrl.sv]
module ttcw_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [ttcw_pkg::REQ_W-1:0]  req_type,
  input  logic [ttcw_pkg::CHAR_W-1:0] char_code,
  input  logic [ttcw_pkg::COL_W-1:0]  col_value,
  input  logic [ttcw_pkg::ROW_W-1:0]  row_value,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output logic [ttcw_pkg::OFFS_W-1:0] cursor_offset,
  output logic [ttcw_pkg::CELL_W-1:0] cell_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ttcw_pkg::ATTR_W-1:0] cfg_attr,
  output ttcw_pkg::mem_wr_t           mem_wr,
  output ttcw_pkg::mem_rd_t           mem_rd,
  input  logic [ttcw_pkg::CELL_W-1:0] mem_rd_data
);
  import ttcw_pkg::*;

  state_e            state, state_next;
  logic [ATTR_W-1:0] color_attr;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  logic [COL_W-1:0]  cursor_col, cursor_col_next;
  logic [ROW_W-1:0]  row_base, row_base_next;
  logic [ADDR_W-1:0] fill_addr, fill_addr_next;
  logic [ADDR_W-1:0] fill_end, fill_end_next;
  logic [ATTR_W-1:0] fill_attr, fill_attr_next;

  req_type_e         req_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;

  logic [COL_SUM_W-1:0] col_sum;
  logic                 put_write;
  logic                 do_nl;
  logic                 at_bottom;
  logic                 fill_last;
  logic                 out_load;
  logic [COL_W-1:0]     col_clamped;
  logic [ROW_W-1:0]     row_clamped;
  logic [ADDR_W-1:0]    cursor_addr;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                input logic [ROW_W-1:0] base);
    logic [ROW_W:0] sum;
    sum = {1'b0, row} + {1'b0, base};
    if (sum >= (ROW_W+1)'(SCREEN_ROWS)) begin
      sum = sum - (ROW_W+1)'(SCREEN_ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  assign req_ready   = (state == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign fill_last   = (fill_addr == fill_end);
  assign out_load    = (state == ST_DONE) && (!rsp_valid || rsp_ready);
  assign col_clamped = ({1'b0, col_q} >= (COL_W+1)'(SCREEN_COLUMNS)) ?
                       COL_W'(SCREEN_COLUMNS - 1) : col_q;
  assign row_clamped = ({1'b0, row_q} >= (ROW_W+1)'(SCREEN_ROWS)) ?
                       ROW_W'(SCREEN_ROWS - 1) : row_q;
  assign cursor_addr = cell_addr(cursor_row, cursor_col);

  // Decode the put character against the current cursor
  always_comb begin
    col_sum   = {1'b0, cursor_col};
    put_write = 1'b0;
    do_nl     = 1'b0;
    unique case (char_q)
      NEWLINE_CHAR: do_nl = 1'b1;
      CR_CHAR:      col_sum = '0;
      TAB_CHAR:     col_sum = col_sum + COL_SUM_W'(TAB_STEP);
      BLANK_CHAR:   col_sum = col_sum + COL_SUM_W'(1);
      default: begin
        put_write = 1'b1;
        col_sum   = col_sum + COL_SUM_W'(1);
      end
    endcase
    if (col_sum >= COL_SUM_W'(SCREEN_COLUMNS)) begin
      do_nl = 1'b1;
    end
    at_bottom = ({1'b0, cursor_row} + (ROW_W+1)'(1)) >= (ROW_W+1)'(SCREEN_ROWS);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (fill_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_PUT:   state_next = (do_nl && at_bottom) ? ST_FILL : ST_DONE;
          REQ_CLEAR: state_next = ST_FILL;
          REQ_SET:   state_next = ST_DONE;
          REQ_READ:  state_next = ST_DONE;
        endcase
      end
      ST_FILL: begin
        if (fill_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // Cursor, row base and fill sweep updates
  always_comb begin
    cursor_row_next = cursor_row;
    cursor_col_next = cursor_col;
    row_base_next   = row_base;
    fill_addr_next  = fill_addr;
    fill_end_next   = fill_end;
    fill_attr_next  = fill_attr;
    unique case (state)
      ST_INIT, ST_FILL: begin
        if (!fill_last) fill_addr_next = fill_addr + ADDR_W'(1);
      end
      ST_EXEC: begin
        unique case (req_q)
          REQ_PUT: begin
            if (do_nl) begin
              cursor_col_next = '0;
              if (at_bottom) begin
                // Scroll: advance the top row, blank the old top as the new bottom
                cursor_row_next = ROW_W'(SCREEN_ROWS - 1);
                row_base_next   = phys_row(row_base, ROW_W'(1));
                fill_addr_next  = cell_addr(row_base, '0);
                fill_end_next   = cell_addr(row_base, '0) + ADDR_W'(SCREEN_COLUMNS - 1);
                fill_attr_next  = color_attr;
              end else begin
                cursor_row_next = cursor_row + ROW_W'(1);
              end
            end else begin
              cursor_col_next = col_sum[COL_W-1:0];
            end
          end
          REQ_CLEAR: begin
            cursor_row_next = '0;
            cursor_col_next = '0;
            row_base_next   = '0;
            fill_addr_next  = '0;
            fill_end_next   = ADDR_W'(CELL_COUNT - 1);
            fill_attr_next  = color_attr;
          end
          REQ_SET: begin
            cursor_row_next = row_clamped;
            cursor_col_next = col_clamped;
          end
          REQ_READ: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_wr = '0;
    mem_rd = '0;
    unique case (state)
      ST_INIT, ST_FILL: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = fill_addr;
        mem_wr.data = make_cell(BLANK_CHAR, fill_attr);
      end
      ST_EXEC: begin
        if (req_q == REQ_PUT && put_write) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = cell_addr(phys_row(cursor_row, row_base), cursor_col);
          mem_wr.data = make_cell(char_q, color_attr);
        end
        if (req_q == REQ_READ) begin
          mem_rd.en   = 1'b1;
          mem_rd.addr = cell_addr(phys_row(row_clamped, row_base), col_clamped);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      color_attr <= RESET_ATTR;
      cursor_row <= '0;
      cursor_col <= '0;
      row_base   <= '0;
      fill_addr  <= '0;
      fill_end   <= ADDR_W'(CELL_COUNT - 1);
      fill_attr  <= RESET_ATTR;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cursor_row <= cursor_row_next;
      cursor_col <= cursor_col_next;
      row_base   <= row_base_next;
      fill_addr  <= fill_addr_next;
      fill_end   <= fill_end_next;
      fill_attr  <= fill_attr_next;
      if (cfg_valid) color_attr <= cfg_attr;
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q  <= req_type_e'(req_type);
      char_q <= char_code;
      col_q  <= col_value;
      row_q  <= row_value;
    end
    if (out_load) begin
      cursor_offset <= OFFS_W'(cursor_addr);
      cell_data     <= (req_q == REQ_READ) ? mem_rd_data : '0;
    end
  end

endmodule

[rtl/text_terminal_char_writer_top.sv]
// Text-mode character terminal: a screen of 16-bit cells (attribute byte high,
// character byte low) plus a cursor, driven by one request beat at a time on
// req (put character, clear screen, set cursor, read cell) and answered by
// exactly one response beat on rsp carrying the cursor offset and, for a read,
// the cell. The user must write the color attribute over cfg only while the
// block is idle; the block does not enforce this. Put, set cursor and read
// cell pass through the idle, execute and done states; the response register
// loads in done once rsp is free. A put that scrolls adds one screen row of
// blanking (SCREEN_COLUMNS cells, 80), and clear screen adds a full sweep of
// the screen memory (CELL_COUNT cells, 1920), both through the single write
// port of the screen memory, which blanks one cell per cycle. Scrolling moves
// no cells: the memory is a ring of rows and only the top-row pointer advances.
// After reset the block runs the same full-screen blanking sweep with attribute
// 0x0F and holds req.ready low until it ends; cfg writes are taken throughout.
// A new request is taken while the previous response still waits on rsp.
module text_terminal_char_writer_top (
  input  logic       clk,
  input  logic       rst,
  ttcw_req_if.sink   req,
  ttcw_rsp_if.source rsp,
  ttcw_cfg_if.sink   cfg
);
  import ttcw_pkg::*;

  mem_wr_t           mem_wr;
  mem_rd_t           mem_rd;
  logic [CELL_W-1:0] mem_rd_data;

  // Sequencer: cursor, ring pointer, blanking sweeps and the response register
  ttcw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .req_type      (req.req_type),
    .char_code     (req.char_code),
    .col_value     (req.col_value),
    .row_value     (req.row_value),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .cursor_offset (rsp.cursor_offset),
    .cell_data     (rsp.cell_data),
    .cfg_valid     (cfg.valid),
    .cfg_ready     (cfg.ready),
    .cfg_attr      (cfg.color_attr),
    .mem_wr        (mem_wr),
    .mem_rd        (mem_rd),
    .mem_rd_data   (mem_rd_data)
  );

  // Screen memory: one write port, one registered read port
  ttcw_screen_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd      (mem_rd),
    .rd_data (mem_rd_data)
  );

endmodule

[rtl/ttcw_checker.sv]
module ttcw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_ready,
  input logic                        rsp_valid,
  input logic                        rsp_ready,
  input logic [ttcw_pkg::OFFS_W-1:0] rsp_cursor_offset,
  input logic [ttcw_pkg::CELL_W-1:0] rsp_cell_data
);
  import ttcw_pkg::*;

  logic [2:0] pending;

  // Count requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'((req_valid && req_ready) ? 1 : 0)
                         - 3'((rsp_valid && rsp_ready) ? 1 : 0);
    end
  end

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (rst)
    (pending <= 3'd2) && (!rsp_valid || pending != 3'd0))
    else $error("response without request or too many requests in flight");

  a_offset_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (int'(rsp_cursor_offset) < CELL_COUNT))
    else $error("cursor offset beyond screen");

  a_busy_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !req_ready)
    else $error("request taken during reset blanking");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cursor_offset)
                                && $stable(rsp_cell_data))
    else $error("stalled response beat changed");

endmodule

bind text_terminal_char_writer_top ttcw_checker u_ttcw_checker (
  .clk               (clk),
  .rst               (rst),
  .req_valid         (req.valid),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_cursor_offset (rsp.cursor_offset),
  .rsp_cell_data     (rsp.cell_data)
);
